@@ src/fqs_pkg.sv @@
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types and constants for the FIFO queue with search: operation and
// status codes, sequencer states and the fixed field widths.
// ----------------------------------------------------------------------------
package fqs_pkg;

	// fixed field widths
	localparam int DATA_W        = 32;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;
	localparam int OCC_W         = 5;
	localparam int DEPTH_DEFAULT = 16;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_FIND    = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FRONT,
		S_DONE
	} state_t;

endpackage

@@ src/fqs_cmd_if.sv @@
// ----------------------------------------------------------------------------
// fqs_cmd_if
// Command channel: one operation and its operand word per item.
// ----------------------------------------------------------------------------
interface fqs_cmd_if;

	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);

endinterface

@@ src/fqs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fqs_rsp_if
// Response channel: status, front word, occupancy and search result per item.
// ----------------------------------------------------------------------------
interface fqs_rsp_if;

	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        front_valid;
	logic [31:0] front_value;
	logic [4:0]  occupancy;
	logic        found;
	logic [4:0]  position;

	modport source (output valid, output status, output front_valid, output front_value,
		output occupancy, output found, output position, input ready);
	modport sink   (input valid, input status, input front_valid, input front_value,
		input occupancy, input found, input position, output ready);

endinterface

@@ src/fifo_queue_with_search.sv @@
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// Bounded FIFO of 32-bit signed words held in a ring memory, with enqueue,
// dequeue, clear and a find that scans from the front.
// ----------------------------------------------------------------------------
// Usage
//   cmd carries one operation per item (op, value); rsp returns exactly one
//   item per command: status, front word with its valid flag, occupancy and,
//   for find, found and the 1-based position of the first match.
//   The ring is a synchronous memory with one write port and a registered
//   read port; head, tail and count live in registers.
// Sequence
//   enqueue, dequeue and clear: the item passes the execute, front-read and
//   done states, then its result is registered; cmd is accepted only in idle.
//   find: a scan after execute compares n entries (at most the
//   occupancy), one entry per cycle through the ring's read port.
// Reset
//   head, tail and count go to zero, the queue is empty; the ring contents are
//   not cleared and only entries written since are ever read.
// Stalls
//   a finished result waits in the output register; while it is held and a
//   further result is ready, the sequencer waits and cmd.ready stays low.
// ----------------------------------------------------------------------------
module fifo_queue_with_search import fqs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	fqs_cmd_if.sink     cmd,
	fqs_rsp_if.source   rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	// ring memory
	logic [DATA_W-1:0] ring_mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;

	// queue pointers
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;

	// item being worked on
	op_t               op_q;
	logic [DATA_W-1:0] value_q;
	status_t           status_q;
	logic              found_q;
	logic [CW-1:0]     pos_q;

	// scan progress
	logic [AW-1:0] scan_slot_q;
	logic [CW-1:0] cmp_k_q;
	logic          scan_hit;
	logic          scan_last;

	// output register
	logic              out_valid_q;
	status_t           out_status_q;
	logic              out_front_valid_q;
	logic [DATA_W-1:0] out_front_value_q;
	logic [OCC_W-1:0]  out_occ_q;
	logic              out_found_q;
	logic [OCC_W-1:0]  out_pos_q;

	state_t state_q, state_d;
	logic   accept;
	logic   load_out;

	function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] slot);
		return (slot == LAST_SLOT) ? '0 : slot + AW'(1);
	endfunction

	assign accept    = cmd.valid && cmd.ready;
	assign scan_hit  = (rd_data_q == value_q);
	assign scan_last = ((cmp_k_q + CW'(1)) == count_q);
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		rd_addr   = head_q;
		wr_en     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// first scan read is the head slot
				wr_en   = (op_q == OP_ENQUEUE) && (count_q != FULL_CNT);
				rd_addr = head_q;
				if (op_q == OP_FIND && count_q != '0) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_FRONT;
				end
			end
			S_SCAN: begin
				rd_addr = scan_slot_q;
				if (scan_hit || scan_last) begin
					state_d = S_FRONT;
				end
			end
			S_FRONT: begin
				rd_addr = head_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				// keep reading the head so the front word stays put
				rd_addr = head_q;
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ring write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[tail_q] <= value_q;
		end
		rd_data_q <= ring_mem[rd_addr];
	end

	// pointers and per-item state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			status_q <= ST_OK;
			found_q  <= 1'b0;
			pos_q    <= '0;
		end else begin
			unique case (state_q)
				S_EXEC: begin
					status_q <= ST_OK;
					found_q  <= 1'b0;
					pos_q    <= '0;
					unique case (op_q)
						OP_ENQUEUE: begin
							if (count_q == FULL_CNT) begin
								status_q <= ST_FULL;
							end else begin
								tail_q  <= wrap_next(tail_q);
								count_q <= count_q + CW'(1);
							end
						end
						OP_DEQUEUE: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								head_q  <= wrap_next(head_q);
								count_q <= count_q - CW'(1);
							end
						end
						OP_CLEAR: begin
							head_q  <= '0;
							tail_q  <= '0;
							count_q <= '0;
						end
						OP_FIND: begin
						end
						default: begin
						end
					endcase
				end
				S_SCAN: begin
					if (scan_hit) begin
						found_q <= 1'b1;
						pos_q   <= cmp_k_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// command capture and scan counters
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(cmd.op);
			value_q <= cmd.value;
		end
		if (state_q == S_EXEC) begin
			scan_slot_q <= wrap_next(head_q);
			cmp_k_q     <= '0;
		end else if (state_q == S_SCAN) begin
			scan_slot_q <= wrap_next(scan_slot_q);
			cmp_k_q     <= cmp_k_q + CW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q      <= status_q;
			out_front_valid_q <= (count_q != '0);
			out_front_value_q <= (count_q != '0) ? rd_data_q : '0;
			out_occ_q         <= OCC_W'(count_q);
			out_found_q       <= found_q;
			out_pos_q         <= OCC_W'(pos_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.front_valid = out_front_valid_q;
	assign rsp.front_value = out_front_value_q;
	assign rsp.occupancy   = out_occ_q;
	assign rsp.found       = out_found_q;
	assign rsp.position    = out_pos_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> cmp_k_q < count_q)
		else $error("scan past stored entries");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && op_q == OP_CLEAR) |=> count_q == '0)
		else $error("clear left entries behind");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && state_q == S_IDLE)
		else $error("loaded result not presented");

	// a match flag is only meaningful once the scan has finished
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && (state_q == S_FRONT || state_q == S_DONE))
		|-> (op_q == OP_FIND && status_q == ST_OK))
		else $error("match flagged outside a find");

endmodule
